// File: rtl/core/ppm_hdr_pkg.sv
// ----------------------------------------------------------------------------
// PPM header parser package
// Shared types, codes and byte classification helpers for the P6 header
// parser.
// ----------------------------------------------------------------------------
package ppm_hdr_pkg;

	localparam int unsigned ACC_W      = 17;
	localparam int unsigned OUT_W      = 16;
	localparam int unsigned DIM_BITS_D = 16;

	localparam logic [ACC_W-1:0] ACC_SAT = 17'h1FFFF;

	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_SIX  = 8'h36;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;

	typedef enum logic [9:0] {
		PH_P      = 10'b00_0000_0001,
		PH_SIX    = 10'b00_0000_0010,
		PH_MAGIC  = 10'b00_0000_0100,
		PH_WS_W   = 10'b00_0000_1000,
		PH_WIDTH  = 10'b00_0001_0000,
		PH_WS_H   = 10'b00_0010_0000,
		PH_HEIGHT = 10'b00_0100_0000,
		PH_WS_M   = 10'b00_1000_0000,
		PH_MAXVAL = 10'b01_0000_0000,
		PH_END    = 10'b10_0000_0000
	} phase_t;

	typedef enum logic [1:0] {
		ST_PENDING  = 2'd0,
		ST_DONE     = 2'd1,
		ST_ERROR    = 2'd2,
		ST_FINISHED = 2'd3
	} status_t;

	typedef struct packed {
		phase_t           phase;
		logic             in_comment;
		logic [ACC_W-1:0] width_acc;
		logic [ACC_W-1:0] height_acc;
		logic [ACC_W-1:0] maxval_acc;
		logic             finished;
		logic             succeeded;
	} hdr_state_t;

	typedef struct packed {
		status_t          status;
		logic             header_ok;
		logic [OUT_W-1:0] image_width;
		logic [OUT_W-1:0] image_height;
		logic [OUT_W-1:0] max_sample;
		logic             two_byte_samples;
	} hdr_result_t;

	localparam hdr_state_t HDR_STATE_RST = '{
		phase:      PH_P,
		in_comment: 1'b0,
		width_acc:  '0,
		height_acc: '0,
		maxval_acc: '0,
		finished:   1'b0,
		succeeded:  1'b0
	};

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	// acc * 10 + digit, saturating
	function automatic logic [ACC_W-1:0] accumulate(input logic [ACC_W-1:0] acc,
		input logic [7:0] c);
		logic [ACC_W+4:0] v;
		v = {2'b00, acc, 3'b000} + {4'b0000, acc, 1'b0} + {18'd0, c[3:0]};
		if (v > {5'd0, ACC_SAT}) begin
			return ACC_SAT;
		end
		return v[ACC_W-1:0];
	endfunction

endpackage

// File: rtl/core/ppm_header_parser.sv
// ----------------------------------------------------------------------------
// PPM P6 header parser
// Byte-stream parser for the header of a binary PPM image.
// ----------------------------------------------------------------------------
// One word in, one word out: every byte accepted yields exactly one result
// word. A byte is latched into an input register, checked against the parser
// state by a single level of logic and, with the state update, written into
// the result register, so the block sustains one byte per clock while the
// output is not stalled. The input side takes a byte while a result waits
// only if the input register is empty, then holds until the result is taken.
// Set restart with the first byte of each new header;
// after completion or an error every byte reports "already finished" until
// the next restart.
module ppm_header_parser #(
	parameter int unsigned DIM_BITS = ppm_hdr_pkg::DIM_BITS_D
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     status,
	output logic                           header_ok,
	output logic [ppm_hdr_pkg::OUT_W-1:0]  image_width,
	output logic [ppm_hdr_pkg::OUT_W-1:0]  image_height,
	output logic [ppm_hdr_pkg::OUT_W-1:0]  max_sample,
	output logic                           two_byte_samples
);
	import ppm_hdr_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        restart_s1;
	logic        advance;
	hdr_state_t  state_q;
	hdr_state_t  state_nxt;
	hdr_result_t res_nxt;
	hdr_result_t res_q;
	logic        out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	ppm_hdr_step #(
		.DIM_BITS(DIM_BITS)
	) u_step (
		.cur      (state_q),
		.data_byte(data_s1),
		.restart  (restart_s1),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= HDR_STATE_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = res_q.status;
	assign header_ok        = res_q.header_ok;
	assign image_width      = res_q.image_width;
	assign image_height     = res_q.image_height;
	assign max_sample       = res_q.max_sample;
	assign two_byte_samples = res_q.two_byte_samples;

endmodule

// File: rtl/core/ppm_hdr_step.sv
// ----------------------------------------------------------------------------
// PPM header parser step logic
// Next parser state and result word for one byte against the current state.
// ----------------------------------------------------------------------------
module ppm_hdr_step #(
	parameter int unsigned DIM_BITS = ppm_hdr_pkg::DIM_BITS_D
) (
	input  ppm_hdr_pkg::hdr_state_t  cur,
	input  logic [7:0]               data_byte,
	input  logic                     restart,
	output ppm_hdr_pkg::hdr_state_t  nxt,
	output ppm_hdr_pkg::hdr_result_t res
);
	import ppm_hdr_pkg::*;

	localparam logic [32:0] DIM_LIM = (33'd1 << DIM_BITS) - 33'd1;

	hdr_state_t       st;
	logic             ok;
	logic             c_ws;
	logic             c_dig;
	logic             c_hash;
	logic [ACC_W-1:0] acc_w;
	logic [ACC_W-1:0] acc_h;
	logic [ACC_W-1:0] acc_m;
	logic             w_ok;
	logic             h_ok;
	logic             m_ok;

	assign st     = restart ? HDR_STATE_RST : cur;
	assign c_ws   = is_ws(data_byte);
	assign c_dig  = is_digit(data_byte);
	assign c_hash = (data_byte == CH_HASH);
	assign acc_w  = accumulate(st.width_acc, data_byte);
	assign acc_h  = accumulate(st.height_acc, data_byte);
	assign acc_m  = accumulate(st.maxval_acc, data_byte);

	assign w_ok = (st.width_acc != '0) && !st.width_acc[ACC_W-1] &&
		({16'd0, st.width_acc} <= DIM_LIM);
	assign h_ok = (st.height_acc != '0) && !st.height_acc[ACC_W-1] &&
		({16'd0, st.height_acc} <= DIM_LIM);
	assign m_ok = (st.maxval_acc != '0) && !st.maxval_acc[ACC_W-1];

	always_comb begin
		nxt        = st;
		res.status = ST_PENDING;
		ok         = 1'b1;
		if (st.finished) begin
			res.status = ST_FINISHED;
		end else if (st.in_comment) begin
			if (data_byte == CH_LF) begin
				nxt.in_comment = 1'b0;
			end
		end else begin
			case (st.phase)
				PH_P: begin
					if (data_byte == CH_P) nxt.phase = PH_SIX; else ok = 1'b0;
				end
				PH_SIX: begin
					if (data_byte == CH_SIX) nxt.phase = PH_MAGIC; else ok = 1'b0;
				end
				PH_MAGIC: begin
					if (c_hash || c_ws) begin
						nxt.in_comment = c_hash;
						nxt.phase      = PH_WS_W;
					end else begin
						ok = 1'b0;
					end
				end
				PH_WS_W: begin
					if (c_hash) begin
						nxt.in_comment = 1'b1;
					end else if (c_dig) begin
						nxt.width_acc = acc_w;
						nxt.phase     = PH_WIDTH;
					end else if (!c_ws) begin
						ok = 1'b0;
					end
				end
				PH_WIDTH: begin
					if (c_hash || c_ws) begin
						nxt.in_comment = c_hash;
						nxt.phase      = PH_WS_H;
					end else if (c_dig) begin
						nxt.width_acc = acc_w;
					end else begin
						ok = 1'b0;
					end
				end
				PH_WS_H: begin
					if (c_hash) begin
						nxt.in_comment = 1'b1;
					end else if (c_dig) begin
						nxt.height_acc = acc_h;
						nxt.phase      = PH_HEIGHT;
					end else if (!c_ws) begin
						ok = 1'b0;
					end
				end
				PH_HEIGHT: begin
					if (c_hash || c_ws) begin
						nxt.in_comment = c_hash;
						nxt.phase      = PH_WS_M;
					end else if (c_dig) begin
						nxt.height_acc = acc_h;
					end else begin
						ok = 1'b0;
					end
				end
				PH_WS_M: begin
					if (c_hash) begin
						nxt.in_comment = 1'b1;
					end else if (c_dig) begin
						nxt.maxval_acc = acc_m;
						nxt.phase      = PH_MAXVAL;
					end else if (!c_ws) begin
						ok = 1'b0;
					end
				end
				PH_MAXVAL: begin
					if (c_hash || c_ws) begin
						nxt.in_comment = c_hash;
						nxt.phase      = PH_END;
					end else if (c_dig) begin
						nxt.maxval_acc = acc_m;
					end else begin
						ok = 1'b0;
					end
				end
				PH_END: begin
					if (w_ok && h_ok && m_ok) begin
						nxt.succeeded = 1'b1;
						nxt.finished  = 1'b1;
						res.status    = ST_DONE;
					end else begin
						ok = 1'b0;
					end
				end
				default: begin
					ok = 1'b0;
				end
			endcase
			if (!ok) begin
				nxt.finished  = 1'b1;
				nxt.succeeded = 1'b0;
				res.status    = ST_ERROR;
			end
		end

		res.header_ok        = nxt.succeeded;
		res.image_width      = '0;
		res.image_height     = '0;
		res.max_sample       = '0;
		res.two_byte_samples = 1'b0;
		if (nxt.succeeded) begin
			res.image_width      = nxt.width_acc[OUT_W-1:0];
			res.image_height     = nxt.height_acc[OUT_W-1:0];
			res.max_sample       = nxt.maxval_acc[OUT_W-1:0];
			res.two_byte_samples = |nxt.maxval_acc[ACC_W-1:8];
		end
	end

endmodule
